// ===== rtl/sfs_pkg.sv =====
// Shared types, codes and widths of the screen fade sequencer.
package sfs_pkg;

	localparam int TIME_WIDTH      = 16;
	localparam int ELAPSED_WIDTH   = TIME_WIDTH + 1;
	localparam int ALPHA_WIDTH     = 8;
	localparam int NUM_WIDTH       = ALPHA_WIDTH + TIME_WIDTH;
	localparam int STEP_WIDTH      = $clog2(ALPHA_WIDTH);
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_INDEX_WIDTH = 2;

	// request codes
	localparam logic [1:0] REQ_TICK     = 2'd0;
	localparam logic [1:0] REQ_ACTIVATE = 2'd1;
	localparam logic [1:0] REQ_DISABLE  = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FADE_DUR   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNFADE_DUR = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_ALPHA = 2'd2;

	typedef enum logic [1:0] {
		PH_OFF    = 2'd0,
		PH_FADE   = 2'd1,
		PH_UNFADE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		MD_FADE        = 2'd0,
		MD_UNFADE      = 2'd1,
		MD_FADE_UNFADE = 2'd2,
		MD_UNFADE_FADE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [1:0]            fade_mode;
		logic [TIME_WIDTH-1:0] tick_amount;
	} req_t;

	typedef struct packed {
		logic                   active;
		logic [1:0]             phase;
		logic [ALPHA_WIDTH-1:0] alpha;
	} rsp_t;

	// work handed from front to back: either a finished alpha or a division
	typedef struct packed {
		phase_t                 phase;
		logic                   bypass;
		logic [ALPHA_WIDTH-1:0] alpha;
		logic [NUM_WIDTH-1:0]   num;
		logic [TIME_WIDTH-1:0]  divisor;
	} job_t;

endpackage

// ===== rtl/sfs_front.sv =====
// Front end: request decode, phase/elapsed state update, division job setup.
module sfs_front import sfs_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  req_t                       req,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [TIME_WIDTH-1:0]      cfg_data,
	output logic                       job_valid,
	input  logic                       job_full,
	output job_t                       job
);

	logic [TIME_WIDTH-1:0]    fade_dur_q;
	logic [TIME_WIDTH-1:0]    unfade_dur_q;
	logic [ALPHA_WIDTH-1:0]   base_alpha_q;
	phase_t                   phase_q;
	mode_t                    mode_q;
	logic [ELAPSED_WIDTH-1:0] elapsed_q;
	logic                     pend_q;

	phase_t                   phase_d;
	mode_t                    mode_d;
	logic [ELAPSED_WIDTH-1:0] elapsed_d;
	logic [ELAPSED_WIDTH:0]   sum;
	logic [ELAPSED_WIDTH-1:0] sat;
	logic                     accept;

	assign accept    = req_valid && !pend_q;
	assign req_stall = pend_q;
	assign cfg_ready = 1'b1;
	assign job_valid = pend_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_dur_q   <= '0;
			unfade_dur_q <= '0;
			base_alpha_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FADE_DUR:   fade_dur_q   <= cfg_data;
				REG_UNFADE_DUR: unfade_dur_q <= cfg_data;
				REG_BASE_ALPHA: base_alpha_q <= cfg_data[ALPHA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// saturating tick add
	assign sum = {1'b0, elapsed_q} + {{(ELAPSED_WIDTH-TIME_WIDTH+1){1'b0}}, req.tick_amount};
	assign sat = sum[ELAPSED_WIDTH] ? {ELAPSED_WIDTH{1'b1}} : sum[ELAPSED_WIDTH-1:0];

	// next phase, mode and elapsed count
	always_comb begin
		phase_d   = phase_q;
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		unique case (req.req_type)
			REQ_TICK: begin
				if (phase_q == PH_FADE) begin
					elapsed_d = sat;
					if (sat > {1'b0, fade_dur_q}) begin
						if (mode_q == MD_FADE || mode_q == MD_UNFADE_FADE) begin
							phase_d   = PH_OFF;
							elapsed_d = '0;
						end else begin
							phase_d   = PH_UNFADE;
							elapsed_d = sat - {1'b0, fade_dur_q};
						end
					end
				end else if (phase_q == PH_UNFADE) begin
					elapsed_d = sat;
					if (sat > {1'b0, unfade_dur_q}) begin
						if (mode_q == MD_UNFADE || mode_q == MD_FADE_UNFADE) begin
							phase_d   = PH_OFF;
							elapsed_d = '0;
						end else begin
							phase_d   = PH_FADE;
							elapsed_d = sat - {1'b0, unfade_dur_q};
						end
					end
				end
			end
			REQ_ACTIVATE: begin
				mode_d  = mode_t'(req.fade_mode);
				phase_d = (mode_d == MD_FADE || mode_d == MD_FADE_UNFADE) ? PH_FADE
					: PH_UNFADE;
			end
			REQ_DISABLE: begin
				phase_d   = PH_OFF;
				elapsed_d = '0;
			end
			default: ;
		endcase
	end

	// state registers; one word held until its job is queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OFF;
			mode_q    <= MD_FADE;
			elapsed_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				mode_q    <= mode_d;
				elapsed_q <= elapsed_d;
				pend_q    <= 1'b1;
			end else if (pend_q && !job_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	// job from the updated state: trivial cases bypass the divider
	logic [TIME_WIDTH-1:0] mul_op;
	logic                  at_end_fade;
	logic                  at_end_unfade;

	assign at_end_fade   = elapsed_q >= {1'b0, fade_dur_q};
	assign at_end_unfade = elapsed_q >= {1'b0, unfade_dur_q};

	always_comb begin
		job.phase   = phase_q;
		job.bypass  = 1'b1;
		job.alpha   = '0;
		job.divisor = fade_dur_q;
		mul_op      = elapsed_q[TIME_WIDTH-1:0];
		unique case (phase_q)
			PH_FADE: begin
				if (fade_dur_q == '0 || at_end_fade) begin
					job.alpha = base_alpha_q;
				end else begin
					job.bypass = 1'b0;
				end
			end
			PH_UNFADE: begin
				job.divisor = unfade_dur_q;
				mul_op      = unfade_dur_q - elapsed_q[TIME_WIDTH-1:0];
				if (!(unfade_dur_q == '0 || at_end_unfade)) begin
					job.bypass = 1'b0;
				end
			end
			default: ;
		endcase
		job.num = {{TIME_WIDTH{1'b0}}, base_alpha_q} * {{ALPHA_WIDTH{1'b0}}, mul_op};
	end

endmodule

// ===== rtl/sfs_queue.sv =====
// Short job queue between front and back.
module sfs_queue import sfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sfs_back.sv =====
// Back end: bit-serial alpha divider and result register.
module sfs_back import sfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_pop,
	input  job_t job,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	back_state_t            state_q;
	back_state_t            state_d;
	logic [STEP_WIDTH-1:0]  cnt_q;
	logic [TIME_WIDTH-1:0]  rem_q;
	logic [TIME_WIDTH-1:0]  div_q;
	logic [ALPHA_WIDTH-1:0] low_q;
	logic [ALPHA_WIDTH-1:0] quo_q;
	phase_t                 phase_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic [TIME_WIDTH:0]    trial;
	logic                   ge;
	logic [TIME_WIDTH:0]    diff;
	logic                   load_rsp;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one restoring step: quotient is known to fit in ALPHA_WIDTH bits
	assign trial = {rem_q, low_q[ALPHA_WIDTH-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job.bypass ? BK_DONE : BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == STEP_WIDTH'(ALPHA_WIDTH - 1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) begin
			phase_q <= job.phase;
			quo_q   <= job.alpha;
			rem_q   <= job.num[NUM_WIDTH-1:ALPHA_WIDTH];
			low_q   <= job.num[ALPHA_WIDTH-1:0];
			div_q   <= job.divisor;
			cnt_q   <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= ge ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
			low_q <= {low_q[ALPHA_WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[ALPHA_WIDTH-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.active <= phase_q != PH_OFF;
			rsp_q.phase  <= phase_q;
			rsp_q.alpha  <= quo_q;
		end
	end

endmodule

// ===== rtl/screen_fade_sequencer_core.sv =====
// Screen fade sequencer top level: front end, job queue and divider back end.
// A request word that needs a division passes the front end, the job queue, the 8-step
// serial divider and the result register; a trivial alpha (off, zero or ended phase)
// bypasses the divider. The back end works on one job at a time, and the front end
// takes a new word only once the last one's job is queued, while the queue has room.
// Reset (arst_n low): phase off, fade mode, elapsed zero, registers zero, queue empty.
module screen_fade_sequencer_core import sfs_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  req_t                       req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output rsp_t                       rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [TIME_WIDTH-1:0]      cfg_data
);

	logic push;
	logic full;
	logic pop;
	logic q_valid;
	job_t push_job;
	job_t pop_job;

	sfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (push),
		.job_full  (full),
		.job       (push_job)
	);

	sfs_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (pop_job)
	);

	sfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_pop   (pop),
		.job       (pop_job),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the screen fade sequencer core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sfs_pkg::*;

	// request type with no meaning, and the register index past the list
	localparam logic [1:0]                 REQ_IGNORED = 2'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE   = 2'd3;
	localparam logic [ELAPSED_WIDTH:0]     ELAPSED_TOP = {1'b0, {ELAPSED_WIDTH{1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [TIME_WIDTH-1:0] cfg_data = '0;

	// register copies and fader state as the bench tracks them
	logic [TIME_WIDTH-1:0]    fade_len = '0;
	logic [TIME_WIDTH-1:0]    unfade_len = '0;
	logic [ALPHA_WIDTH-1:0]   full_alpha = '0;
	phase_t                   track_phase = PH_OFF;
	mode_t                    track_mode = MD_FADE;
	logic [ELAPSED_WIDTH-1:0] track_elapsed = '0;

	req_t req_backlog[$];
	rsp_t pending_rsp[$];
	rsp_t oldest_rsp;
	int queued_words = 0;
	int accepted_words = 0;
	int checked_words = 0;
	int reg_writes = 0;
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;

	screen_fade_sequencer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the tracked fader by one request word and return its result word
	function automatic rsp_t fade_step(req_t w);
		logic [ELAPSED_WIDTH:0] sum;
		logic [31:0] num;
		logic [31:0] q;
		rsp_t o;
		case (w.req_type)
			REQ_TICK: begin
				if (track_phase != PH_OFF) begin
					sum = track_elapsed + w.tick_amount;
					track_elapsed = (sum > ELAPSED_TOP) ? '1 : sum[ELAPSED_WIDTH-1:0];
					// at most one phase switch per tick, remainder carried over
					if (track_phase == PH_FADE) begin
						if (track_elapsed > fade_len) begin
							if (track_mode == MD_FADE || track_mode == MD_UNFADE_FADE) begin
								track_phase = PH_OFF;
								track_elapsed = '0;
							end else begin
								track_elapsed = track_elapsed - fade_len;
								track_phase = PH_UNFADE;
							end
						end
					end else if (track_phase == PH_UNFADE) begin
						if (track_elapsed > unfade_len) begin
							if (track_mode == MD_UNFADE || track_mode == MD_FADE_UNFADE) begin
								track_phase = PH_OFF;
								track_elapsed = '0;
							end else begin
								track_elapsed = track_elapsed - unfade_len;
								track_phase = PH_FADE;
							end
						end
					end
				end
			end
			REQ_ACTIVATE: begin
				// elapsed count survives an activate
				track_mode = mode_t'(w.fade_mode);
				track_phase = (track_mode == MD_FADE || track_mode == MD_FADE_UNFADE) ?
					PH_FADE : PH_UNFADE;
			end
			REQ_DISABLE: begin
				track_phase = PH_OFF;
				track_elapsed = '0;
			end
			default: ;
		endcase

		// scaled alpha
		q = '0;
		if (track_phase == PH_FADE) begin
			if (fade_len == '0) begin
				q = 32'(full_alpha);
			end else begin
				num = 32'(full_alpha) * 32'(track_elapsed);
				q = num / 32'(fade_len);
				if (q > 32'(full_alpha))
					q = 32'(full_alpha);
			end
		end else if (track_phase == PH_UNFADE) begin
			if (unfade_len != '0 && track_elapsed < unfade_len) begin
				num = 32'(full_alpha) * (32'(unfade_len) - 32'(track_elapsed));
				q = num / 32'(unfade_len);
			end
		end
		o.active = (track_phase != PH_OFF);
		o.phase = track_phase;
		o.alpha = q[ALPHA_WIDTH-1:0];
		return o;
	endfunction

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	// request driver: presents backlog words, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				pending_rsp.push_back(fade_step(req));
				accepted_words++;
			end
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random stall, compares each accepted word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
						$time, rsp.active, rsp.phase, rsp.alpha);
					errors++;
				end else begin
					oldest_rsp = pending_rsp.pop_front();
					check_field("active", oldest_rsp.active, rsp.active);
					check_field("phase", oldest_rsp.phase, rsp.phase);
					check_field("alpha", oldest_rsp.alpha, rsp.alpha);
					checked_words++;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic push_req(input logic [1:0] kind, input logic [1:0] mode,
		input logic [TIME_WIDTH-1:0] amount);
		req_t w;
		w.req_type = kind;
		w.fade_mode = mode;
		w.tick_amount = amount;
		req_backlog.push_back(w);
		queued_words++;
	endtask

	// wait until every queued word is accepted and answered
	task automatic wait_idle();
		@(posedge clk);
		while (accepted_words != queued_words || pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [TIME_WIDTH-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FADE_DUR:   fade_len = data;
			REG_UNFADE_DUR: unfade_len = data;
			REG_BASE_ALPHA: full_alpha = data[ALPHA_WIDTH-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [TIME_WIDTH-1:0] f, input logic [TIME_WIDTH-1:0] u,
		input logic [TIME_WIDTH-1:0] a, input int sidle, input int ridle);
		wait_idle();
		write_reg(REG_FADE_DUR, f);
		write_reg(REG_UNFADE_DUR, u);
		write_reg(REG_BASE_ALPHA, a);
		write_reg(REG_SPARE, 16'($urandom));
		send_idle = sidle;
		recv_idle = ridle;
	endtask

	// fade sequences: an activate, then ticks sized to the durations, with some noise
	task automatic queue_sequences(input int count);
		int stop;
		int span;
		int pick;
		logic [1:0] kind;
		logic [TIME_WIDTH-1:0] amount;
		stop = queued_words + count;
		while (queued_words < stop) begin
			span = ((fade_len > unfade_len) ? fade_len : unfade_len) / 4 + 1;
			push_req(REQ_ACTIVATE, 2'($urandom_range(3)), 16'($urandom));
			repeat ($urandom_range(20, 3)) begin
				pick = $urandom_range(99);
				amount = 16'($urandom);
				if (pick < 3) begin
					kind = REQ_DISABLE;
				end else if (pick < 6) begin
					kind = REQ_IGNORED;
				end else if (pick < 10) begin
					kind = REQ_ACTIVATE;
				end else begin
					kind = REQ_TICK;
					case ($urandom_range(9))
						0: amount = '0;
						1: amount = '1;
						2: ;
						default: amount = 16'($urandom_range(span));
					endcase
				end
				push_req(kind, 2'($urandom_range(3)), amount);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// zero durations, full alpha from a 16-bit write with upper bits set
		configure(16'd0, 16'd0, 16'hFFFF, 6, 57);
		push_req(REQ_TICK, MD_UNFADE_FADE, 16'hFFFF);   // tick while disabled
		push_req(REQ_IGNORED, MD_UNFADE_FADE, 16'hFFFF);
		push_req(REQ_ACTIVATE, MD_FADE_UNFADE, 16'hFFFF);
		push_req(REQ_TICK, MD_FADE, 16'hFFFF);
		// re-activating keeps elapsed, so it climbs to saturation
		push_req(REQ_ACTIVATE, MD_FADE_UNFADE, 16'h0000);
		push_req(REQ_TICK, MD_FADE, 16'hFFFF);
		push_req(REQ_ACTIVATE, MD_FADE_UNFADE, 16'h0000);
		push_req(REQ_TICK, MD_FADE, 16'hFFFF);
		push_req(REQ_TICK, MD_FADE, 16'h0000);
		push_req(REQ_DISABLE, MD_UNFADE_FADE, 16'hFFFF);
		push_req(REQ_ACTIVATE, MD_UNFADE_FADE, 16'h0000);
		push_req(REQ_TICK, MD_FADE, 16'h0000);
		push_req(REQ_TICK, MD_FADE, 16'h0001);
		push_req(REQ_TICK, MD_FADE, 16'h0000);
		push_req(REQ_ACTIVATE, MD_FADE, 16'h0000);
		push_req(REQ_IGNORED, MD_UNFADE_FADE, 16'hFFFF);
		push_req(REQ_DISABLE, MD_FADE, 16'h0000);
		push_req(REQ_ACTIVATE, MD_UNFADE, 16'h0000);
		push_req(REQ_TICK, MD_FADE, 16'h0001);
		queue_sequences(40);

		// longest durations
		configure(16'hFFFF, 16'hFFFF, 16'h00FF, 6, 57);
		queue_sequences(80);

		configure(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)), 16'($urandom),
			57, 6);
		queue_sequences(80);

		configure(16'd0, 16'($urandom_range(300, 1)), 16'h0080, 57, 6);
		queue_sequences(80);

		// zero alpha, shortest nonzero unfade
		configure(16'($urandom), 16'd1, 16'hFF00, 0, 0);
		queue_sequences(80);

		configure(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)), 16'($urandom),
			0, 0);
		queue_sequences(80);

		wait_idle();
		repeat (16) @(posedge clk);
		$display("Checked %0d result words from %0d requests over six register settings,",
			checked_words, accepted_words);
		$display("with %0d register writes and sender/receiver idling in both directions.",
			reg_writes);
		if (errors == 0)
			$display("** screen_fade_sequencer_core: PASSED **");
		else
			$display("** screen_fade_sequencer_core: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d result words still outstanding", pending_rsp.size());
		$display("** screen_fade_sequencer_core: FAILED **");
		$finish;
	end

endmodule
